/* rtl/scse_pkg.sv */
// package for the sound channel sample engine
// types, constants and the ima adpcm step table; no dependencies
package scse_pkg;

    localparam int FUNC_W = 2;
    localparam int ADDR_W = 27;
    localparam int POS_W = 28;
    localparam int CNT_W = 19;
    localparam int CFG_W = 27;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_DATA = 2'd1;
    localparam logic [1:0] FUNC_KEY_ON = 2'd2;
    localparam logic [1:0] FUNC_KEY_OFF = 2'd3;

    localparam logic [1:0] FMT_PCM8 = 2'd0;
    localparam logic [1:0] FMT_PCM16 = 2'd1;
    localparam logic [1:0] FMT_ADPCM = 2'd2;
    localparam logic [1:0] FMT_PSG = 2'd3;

    localparam logic [1:0] WAIT_NONE = 2'd0;
    localparam logic [1:0] WAIT_SAMPLE = 2'd1;
    localparam logic [1:0] WAIT_HEADER = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic [2:0] REG_FORMAT = 3'd0;
    localparam logic [2:0] REG_REPEAT = 3'd1;
    localparam logic [2:0] REG_RELOAD = 3'd2;
    localparam logic [2:0] REG_LOOP = 3'd3;
    localparam logic [2:0] REG_LENGTH = 3'd4;
    localparam logic [2:0] REG_SOURCE = 3'd5;
    localparam logic [2:0] REG_DUTY = 3'd6;
    localparam logic [2:0] REG_CHANNEL = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STEP,
        ST_DECODE,
        ST_ENDCHK,
        ST_OUT
    } state_t;

    function automatic logic [14:0] adpcm_step(input logic [6:0] idx);
        logic [14:0] t;
        case (idx)
            7'd0: t = 15'd7;      7'd1: t = 15'd8;      7'd2: t = 15'd9;
            7'd3: t = 15'd10;     7'd4: t = 15'd11;     7'd5: t = 15'd12;
            7'd6: t = 15'd13;     7'd7: t = 15'd14;     7'd8: t = 15'd16;
            7'd9: t = 15'd17;     7'd10: t = 15'd19;    7'd11: t = 15'd21;
            7'd12: t = 15'd23;    7'd13: t = 15'd25;    7'd14: t = 15'd28;
            7'd15: t = 15'd31;    7'd16: t = 15'd34;    7'd17: t = 15'd37;
            7'd18: t = 15'd41;    7'd19: t = 15'd45;    7'd20: t = 15'd50;
            7'd21: t = 15'd55;    7'd22: t = 15'd60;    7'd23: t = 15'd66;
            7'd24: t = 15'd73;    7'd25: t = 15'd80;    7'd26: t = 15'd88;
            7'd27: t = 15'd97;    7'd28: t = 15'd107;   7'd29: t = 15'd118;
            7'd30: t = 15'd130;   7'd31: t = 15'd143;   7'd32: t = 15'd157;
            7'd33: t = 15'd173;   7'd34: t = 15'd190;   7'd35: t = 15'd209;
            7'd36: t = 15'd230;   7'd37: t = 15'd253;   7'd38: t = 15'd279;
            7'd39: t = 15'd307;   7'd40: t = 15'd337;   7'd41: t = 15'd371;
            7'd42: t = 15'd408;   7'd43: t = 15'd449;   7'd44: t = 15'd494;
            7'd45: t = 15'd544;   7'd46: t = 15'd598;   7'd47: t = 15'd658;
            7'd48: t = 15'd724;   7'd49: t = 15'd796;   7'd50: t = 15'd876;
            7'd51: t = 15'd963;   7'd52: t = 15'd1060;  7'd53: t = 15'd1166;
            7'd54: t = 15'd1282;  7'd55: t = 15'd1411;  7'd56: t = 15'd1552;
            7'd57: t = 15'd1707;  7'd58: t = 15'd1878;  7'd59: t = 15'd2066;
            7'd60: t = 15'd2272;  7'd61: t = 15'd2499;  7'd62: t = 15'd2749;
            7'd63: t = 15'd3024;  7'd64: t = 15'd3327;  7'd65: t = 15'd3660;
            7'd66: t = 15'd4026;  7'd67: t = 15'd4428;  7'd68: t = 15'd4871;
            7'd69: t = 15'd5358;  7'd70: t = 15'd5894;  7'd71: t = 15'd6484;
            7'd72: t = 15'd7132;  7'd73: t = 15'd7845;  7'd74: t = 15'd8630;
            7'd75: t = 15'd9493;  7'd76: t = 15'd10442; 7'd77: t = 15'd11487;
            7'd78: t = 15'd12635; 7'd79: t = 15'd13899; 7'd80: t = 15'd15289;
            7'd81: t = 15'd16818; 7'd82: t = 15'd18500; 7'd83: t = 15'd20350;
            7'd84: t = 15'd22385; 7'd85: t = 15'd24623; 7'd86: t = 15'd27086;
            7'd87: t = 15'd29794; default: t = 15'd32767;
        endcase
        return t;
    endfunction

endpackage

/* rtl/sound_channel_sample_engine_unit.sv */
// Sound channel sample engine: one channel, PCM8/PCM16/IMA ADPCM/PSG/noise.
// Input channel s_* carries func/cycles/mem_data, result channel m_* carries
// the fetch request and the channel sample. Registers via cfg_we/cfg_index.
// Each input transaction gives exactly one result transaction. A tick adds
// cycles to the phase counter; the sequencer then takes one sample step per
// period through CHECK -> STEP (-> ENDCHK) on one shared 29-bit adder. A
// sample data transaction runs DECODE (ADPCM only) and ENDCHK before any
// further steps. A step that needs memory stops the run and the result shows
// the fetch request; the next data transaction completes it.
// Key on, key off and ignored items go straight to OUT; a tick while playing
// and a header word pass CHECK first, and each step adds STEP and CHECK (and
// ENDCHK for a step before the sample start).
// s_tready is high only in IDLE; the result sits in an output register and
// the next item can be taken in the cycle after it has been consumed.
// Reset (aresetn low, synchronous) stops the channel, clears all state except
// the ADPCM byte register and sets the noise register to all ones.
// A stall on m_tready holds the result. Depends on scse_pkg.
module sound_channel_sample_engine_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // func[1:0], cycles[13:2], mem_data[45:14], zero fill
    input  logic [47:0]                   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // fetch_request[0], fetch_address[27:1], fetch_size[29:28],
    // sample_out[45:30], channel_on[46], zero fill
    output logic [47:0]                   m_tdata,
    input  logic                          cfg_we,
    input  logic [scse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [scse_pkg::CFG_W-1:0]    cfg_data
);
    import scse_pkg::*;

    logic [1:0]  fmt_reg, rep_reg;
    logic [15:0] reload_reg, loop_reg;
    logic [21:0] len_reg;
    logic [26:0] src_reg;
    logic [2:0]  duty_reg;
    logic [3:0]  chan_reg;

    state_t state_reg, state_next;
    logic        playing_reg, playing_next;
    logic signed [15:0] smp_reg, smp_next, lsmp_reg, lsmp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [26:0] tot_reg, tot_next;
    logic [6:0]  idx_reg, idx_next, lidx_reg, lidx_next;
    logic        lcap_reg, lcap_next;
    logic [14:0] lfsr_reg, lfsr_next;
    logic [2:0]  dcnt_reg, dcnt_next;
    logic [1:0]  wait_reg, wait_next;
    logic [26:0] paddr_reg, paddr_next;
    logic [1:0]  psize_reg, psize_next;
    logic [7:0]  byte_reg, byte_next;
    logic        mval_reg, mval_next;

    logic [1:0]  in_func;
    logic [11:0] in_cycles;
    logic [31:0] in_data;
    assign in_func = s_tdata[1:0];
    assign in_cycles = s_tdata[13:2];
    assign in_data = s_tdata[45:14];

    // shared adder
    logic [POS_W:0] add_a, add_b, add_s;
    assign add_s = add_a + add_b;

    logic [CNT_W-1:0] period;
    assign period = {1'b1, 18'd0} - {1'b0, reload_reg, 2'b00};

    logic [2:0] kshift;
    logic [POS_W-1:0] loop_k;
    always_comb begin
        case (fmt_reg)
            FMT_PCM8: kshift = 3'd2;
            FMT_PCM16: kshift = 3'd1;
            default: kshift = 3'd3;
        endcase
        loop_k = {12'd0, loop_reg} << kshift;
    end

    // adpcm decode pieces
    logic [3:0]  nib;
    logic [14:0] stp;
    logic [18:0] prod;
    logic [15:0] diff;
    logic signed [17:0] sdec;
    logic signed [7:0] nidx;
    logic [6:0]  cidx;
    always_comb begin
        nib = pos_reg[0] ? byte_reg[7:4] : byte_reg[3:0];
        cidx = (idx_reg > 7'd88) ? 7'd88 : idx_reg;
        stp = adpcm_step(cidx);
        prod = 19'(({1'b0, nib[2:0], 1'b1}) * stp);
        diff = prod[18:3];
        sdec = nib[3] ? 18'(smp_reg) - 18'(diff) : 18'(smp_reg) + 18'(diff);
        case (nib[2:0])
            3'd4: nidx = 8'(cidx) + 8'sd2;
            3'd5: nidx = 8'(cidx) + 8'sd4;
            3'd6: nidx = 8'(cidx) + 8'sd6;
            3'd7: nidx = 8'(cidx) + 8'sd8;
            default: nidx = 8'(cidx) - 8'sd1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= '0; rep_reg <= '0; reload_reg <= '0; loop_reg <= '0;
            len_reg <= '0; src_reg <= '0; duty_reg <= '0; chan_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FORMAT: fmt_reg <= cfg_data[1:0];
                REG_REPEAT: rep_reg <= cfg_data[1:0];
                REG_RELOAD: reload_reg <= cfg_data[15:0];
                REG_LOOP: loop_reg <= cfg_data[15:0];
                REG_LENGTH: len_reg <= cfg_data[21:0];
                REG_SOURCE: src_reg <= cfg_data[26:0];
                REG_DUTY: duty_reg <= cfg_data[2:0];
                REG_CHANNEL: chan_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; playing_reg <= 1'b0; smp_reg <= '0;
            lsmp_reg <= '0; cnt_reg <= '0; pos_reg <= '0; tot_reg <= '0;
            idx_reg <= '0; lidx_reg <= '0; lcap_reg <= 1'b0;
            lfsr_reg <= 15'h7FFF; dcnt_reg <= '0; wait_reg <= WAIT_NONE;
            paddr_reg <= '0; psize_reg <= '0; mval_reg <= 1'b0;
        end else begin
            state_reg <= state_next; playing_reg <= playing_next;
            smp_reg <= smp_next; lsmp_reg <= lsmp_next; cnt_reg <= cnt_next;
            pos_reg <= pos_next; tot_reg <= tot_next; idx_reg <= idx_next;
            lidx_reg <= lidx_next; lcap_reg <= lcap_next; lfsr_reg <= lfsr_next;
            dcnt_reg <= dcnt_next; wait_reg <= wait_next;
            paddr_reg <= paddr_next; psize_reg <= psize_next;
            mval_reg <= mval_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    always_comb begin
        state_next = state_reg; playing_next = playing_reg; smp_next = smp_reg;
        lsmp_next = lsmp_reg; cnt_next = cnt_reg; pos_next = pos_reg;
        tot_next = tot_reg; idx_next = idx_reg; lidx_next = lidx_reg;
        lcap_next = lcap_reg; lfsr_next = lfsr_reg; dcnt_next = dcnt_reg;
        wait_next = wait_reg; paddr_next = paddr_reg; psize_next = psize_reg;
        byte_next = byte_reg; mval_next = mval_reg;
        add_a = '0; add_b = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (in_func)
                        FUNC_TICK: begin
                            state_next = ST_OUT;
                            if (playing_reg) begin
                                add_a = (POS_W+1)'(cnt_reg);
                                add_b = (POS_W+1)'(in_cycles);
                                cnt_next = (add_s > 29'h7FFFF) ? 19'h7FFFF
                                                              : add_s[CNT_W-1:0];
                                state_next = ST_CHECK;
                            end
                        end
                        FUNC_DATA: begin
                            state_next = ST_OUT;
                            if (playing_reg && wait_reg != WAIT_NONE) begin
                                wait_next = WAIT_NONE;
                                paddr_next = '0; psize_next = '0;
                                state_next = ST_CHECK;
                                if (wait_reg == WAIT_HEADER) begin
                                    smp_next = in_data[15:0];
                                    idx_next = (in_data[22:16] > 7'd88) ? 7'd88
                                                                      : in_data[22:16];
                                    pos_next = 28'd8;
                                end else if (fmt_reg == FMT_PCM8) begin
                                    smp_next = {in_data[7:0], 8'd0};
                                    pos_next = pos_reg + 28'd1;
                                    state_next = ST_ENDCHK;
                                end else if (fmt_reg == FMT_PCM16) begin
                                    smp_next = in_data[15:0];
                                    pos_next = pos_reg + 28'd1;
                                    state_next = ST_ENDCHK;
                                end else if (fmt_reg == FMT_ADPCM) begin
                                    byte_next = in_data[7:0];
                                    state_next = ST_DECODE;
                                end
                            end
                        end
                        FUNC_KEY_ON: begin
                            state_next = ST_OUT;
                            if (!playing_reg) begin
                                playing_next = 1'b1;
                                cnt_next = '0;
                                add_a = (POS_W+1)'(len_reg);
                                add_b = (POS_W+1)'(loop_reg);
                                tot_next = (fmt_reg == FMT_PSG) ? 27'd0
                                         : 27'(add_s[26:0] << kshift);
                                pos_next = -28'sd3;
                                wait_next = WAIT_NONE;
                                if (fmt_reg == FMT_ADPCM) begin
                                    lcap_next = 1'b0;
                                    wait_next = WAIT_HEADER;
                                    paddr_next = src_reg; psize_next = SIZE_WORD;
                                end else if (fmt_reg == FMT_PSG) begin
                                    lfsr_next = 15'h7FFF; dcnt_next = '0;
                                    pos_next = -28'sd1;
                                end
                            end
                        end
                        default: begin
                            playing_next = 1'b0;
                            wait_next = WAIT_NONE;
                            paddr_next = '0; psize_next = '0;
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                add_a = (POS_W+1)'(cnt_reg);
                add_b = ~(POS_W+1)'(period) + 29'd1;
                if (playing_reg && wait_reg == WAIT_NONE && cnt_reg > period) begin
                    cnt_next = add_s[CNT_W-1:0];
                    state_next = ST_STEP;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_STEP: begin
                state_next = ST_CHECK;
                if (fmt_reg == FMT_PSG) begin
                    if (chan_reg >= 4'd14) begin
                        lfsr_next = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ 15'h6000)
                                                : (lfsr_reg >> 1);
                        smp_next = lfsr_reg[0] ? -16'sh8000 : 16'sh7FFF;
                    end else if (chan_reg >= 4'd8) begin
                        smp_next = (dcnt_reg > duty_reg) ? -16'sh8000 : 16'sh7FFF;
                        dcnt_next = dcnt_reg + 3'd1;
                    end else begin
                        smp_next = '0;
                    end
                end else if (!pos_reg[POS_W-1]) begin
                    add_a = (POS_W+1)'(src_reg);
                    case (fmt_reg)
                        FMT_PCM8: add_b = (POS_W+1)'(pos_reg);
                        FMT_PCM16: add_b = (POS_W+1)'({pos_reg, 1'b0});
                        default: add_b = (POS_W+1)'(pos_reg >> 1);
                    endcase
                    wait_next = WAIT_SAMPLE;
                    paddr_next = add_s[26:0];
                    psize_next = (fmt_reg == FMT_PCM16) ? SIZE_HALF : SIZE_BYTE;
                end else begin
                    pos_next = pos_reg + 28'd1;
                    state_next = ST_ENDCHK;
                end
            end
            ST_DECODE: begin
                if (sdec > 18'sh7FFF) smp_next = 16'sh7FFF;
                else if (sdec < -18'sh7FFF) smp_next = -16'sh7FFF;
                else smp_next = sdec[15:0];
                if (nidx < 0) idx_next = '0;
                else if (nidx > 8'sd88) idx_next = 7'd88;
                else idx_next = nidx[6:0];
                if (pos_reg == 28'(loop_k)) begin
                    lsmp_next = smp_next; lidx_next = idx_next; lcap_next = 1'b1;
                end
                pos_next = pos_reg + 28'd1;
                state_next = ST_ENDCHK;
            end
            ST_ENDCHK: begin
                state_next = ST_CHECK;
                add_a = {pos_reg[POS_W-1], pos_reg} - (POS_W+1)'(tot_reg);
                add_b = (POS_W+1)'(loop_k);
                if (fmt_reg != FMT_PSG && !pos_reg[POS_W-1]
                    && pos_reg >= 28'(tot_reg)) begin
                    if (rep_reg != 2'd1) begin
                        playing_next = 1'b0;
                    end else if (fmt_reg == FMT_ADPCM && !lcap_reg) begin
                        wait_next = WAIT_HEADER;
                        paddr_next = src_reg; psize_next = SIZE_WORD;
                    end else begin
                        pos_next = add_s[POS_W-1:0];
                        if (fmt_reg == FMT_ADPCM) begin
                            smp_next = lsmp_reg; idx_next = lidx_reg;
                        end
                    end
                end
            end
            ST_OUT: begin
                mval_next = 1'b1;
                if (mval_reg && m_tready) begin
                    mval_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mval_reg;
    assign m_tdata = {1'b0, playing_reg, smp_reg, psize_reg, paddr_reg,
                      (wait_reg != WAIT_NONE)};

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> s_tready)
        else $error("result not followed by idle");
    a_no_req_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (wait_reg == WAIT_NONE) |-> (paddr_reg == '0 || state_reg != ST_IDLE))
        else $error("stale fetch address");
    a_wait_play: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tready && wait_reg != WAIT_NONE) |-> playing_reg)
        else $error("fetch pending while stopped");

endmodule

/* tb/sound_channel_sample_engine_checker.sv */
// sound channel sample engine checker: watches the register port and both streams,
// keeps its own copy of the channel state and compares every result transaction
// depends on scse_pkg
`timescale 1ns / 1ps

module sound_channel_sample_engine_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [47:0]                    s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [47:0]                    m_tdata,
    input  logic                           cfg_we,
    input  logic [scse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [scse_pkg::CFG_W-1:0]     cfg_data,
    output int                             failures,
    output int                             outstanding
);
    import scse_pkg::*;

    typedef struct packed {
        logic               req;
        logic [ADDR_W-1:0]  addr;
        logic [1:0]         size;
        logic signed [15:0] smp;
        logic               on;
    } chan_result_t;

    localparam int IMA_STEPS [89] = '{
        7, 8, 9, 10, 11, 12, 13, 14, 16, 17, 19, 21, 23, 25, 28, 31, 34, 37, 41,
        45, 50, 55, 60, 66, 73, 80, 88, 97, 107, 118, 130, 143, 157, 173, 190,
        209, 230, 253, 279, 307, 337, 371, 408, 449, 494, 544, 598, 658, 724, 796,
        876, 963, 1060, 1166, 1282, 1411, 1552, 1707, 1878, 2066, 2272, 2499,
        2749, 3024, 3327, 3660, 4026, 4428, 4871, 5358, 5894, 6484, 7132, 7845,
        8630, 9493, 10442, 11487, 12635, 13899, 15289, 16818, 18500, 20350,
        22385, 24623, 27086, 29794, 32767};
    localparam int IDX_ADJUST [8] = '{-1, -1, -1, -1, 2, 4, 6, 8};

    chan_result_t expected_q[$];

    logic [1:0]  fmt, rep;
    logic [15:0] reload, loop_words;
    logic [21:0] len_words;
    logic [26:0] src_addr;
    logic [2:0]  duty;
    logic [3:0]  chan;

    logic               playing, loop_cap;
    logic signed [15:0] cur_smp, loop_smp;
    int                 phase;
    logic signed [27:0] pos;
    logic [26:0]        total;
    int                 step_idx, loop_idx;
    logic [14:0]        lfsr;
    logic [2:0]         duty_cnt;
    logic [1:0]         wait_kind;
    logic [26:0]        pend_addr;
    logic [1:0]         pend_size;

    function automatic int words_to_pos(logic [1:0] f);
        case (f)
            FMT_PCM8:  return 4;
            FMT_PCM16: return 2;
            FMT_ADPCM: return 8;
            default:   return 0;
        endcase
    endfunction

    task automatic clear_state();
        fmt = 0; rep = 0; reload = 0; loop_words = 0;
        len_words = 0; src_addr = 0; duty = 0; chan = 0;
        playing = 0; loop_cap = 0; cur_smp = 0; loop_smp = 0;
        phase = 0; pos = 0; total = 0; step_idx = 0; loop_idx = 0;
        lfsr = 15'h7FFF; duty_cnt = 0; wait_kind = WAIT_NONE;
        pend_addr = 0; pend_size = 0;
        expected_q.delete();
    endtask

    task automatic fetch(logic [1:0] kind, longint addr, logic [1:0] size);
        wait_kind = kind;
        pend_addr = addr[26:0];
        pend_size = size;
    endtask

    task automatic end_of_sample();
        longint p;
        p = longint'(pos);
        if (fmt == FMT_PSG || p < longint'(total)) return;
        if (rep != 2'd1) begin
            playing = 0;
            return;
        end
        if (fmt == FMT_ADPCM && !loop_cap) begin
            fetch(WAIT_HEADER, src_addr, SIZE_WORD);
            return;
        end
        p = p - (longint'(total) - longint'(loop_words) * words_to_pos(fmt));
        pos = p[27:0];
        if (fmt == FMT_ADPCM) begin
            cur_smp = loop_smp;
            step_idx = loop_idx;
        end
    endtask

    task automatic adpcm_nibble(logic [7:0] b);
        logic [3:0] n;
        int idx, diff, s;
        n = pos[0] ? b[7:4] : b[3:0];
        idx = step_idx;
        diff = (int'(n[2:0]) * 2 + 1) * IMA_STEPS[idx] / 8;
        s = cur_smp;
        if (n[3]) begin
            s = s - diff;
            if (s < -32767) s = -32767;
        end else begin
            s = s + diff;
            if (s > 32767) s = 32767;
        end
        cur_smp = s[15:0];
        idx = idx + IDX_ADJUST[n[2:0]];
        if (idx < 0) idx = 0;
        if (idx > 88) idx = 88;
        step_idx = idx;
        if (longint'(pos) == longint'(loop_words) * 8) begin
            loop_smp = cur_smp;
            loop_idx = step_idx;
            loop_cap = 1;
        end
    endtask

    task automatic one_step();
        longint p;
        if (fmt == FMT_PSG) begin
            if (chan >= 14) begin
                cur_smp = lfsr[0] ? -16'sd32768 : 16'sd32767;
                lfsr = lfsr[0] ? ((lfsr >> 1) ^ 15'h6000) : (lfsr >> 1);
            end else if (chan >= 8) begin
                cur_smp = (duty_cnt > duty) ? -16'sd32768 : 16'sd32767;
                duty_cnt = duty_cnt + 1;
            end else begin
                cur_smp = 0;
            end
            return;
        end
        p = longint'(pos);
        if (p >= 0) begin
            case (fmt)
                FMT_PCM8:  fetch(WAIT_SAMPLE, longint'(src_addr) + p, SIZE_BYTE);
                FMT_PCM16: fetch(WAIT_SAMPLE, longint'(src_addr) + p * 2, SIZE_HALF);
                default:   fetch(WAIT_SAMPLE, longint'(src_addr) + (p >> 1), SIZE_BYTE);
            endcase
            return;
        end
        pos = pos + 1;
        end_of_sample();
    endtask

    task automatic run_steps();
        int period;
        period = 32'h40000 - 4 * int'(reload);
        while (playing && wait_kind == WAIT_NONE && phase > period) begin
            phase = phase - period;
            one_step();
        end
    endtask

    task automatic take_data(logic [31:0] d);
        logic [1:0] kind;
        kind = wait_kind;
        wait_kind = WAIT_NONE;
        pend_addr = 0;
        pend_size = 0;
        if (kind == WAIT_HEADER) begin
            cur_smp = d[15:0];
            step_idx = (d[22:16] > 88) ? 88 : int'(d[22:16]);
            pos = 8;
            return;
        end
        if (fmt == FMT_PSG) return;
        case (fmt)
            FMT_PCM8:  cur_smp = {d[7:0], 8'h00};
            FMT_PCM16: cur_smp = d[15:0];
            default:   adpcm_nibble(d[7:0]);
        endcase
        pos = pos + 1;
        end_of_sample();
    endtask

    task automatic channel_item(logic [1:0] func, logic [11:0] cyc, logic [31:0] d,
                                output chan_result_t r);
        logic [31:0] t;
        case (func)
            FUNC_TICK: if (playing) begin
                phase = phase + cyc;
                if (phase > 32'h7FFFF) phase = 32'h7FFFF;
                run_steps();
            end
            FUNC_DATA: if (playing && wait_kind != WAIT_NONE) begin
                take_data(d);
                run_steps();
            end
            FUNC_KEY_ON: if (!playing) begin
                playing = 1;
                phase = 0;
                t = (32'(len_words) + 32'(loop_words)) * words_to_pos(fmt);
                total = t[26:0];
                pos = -28'sd3;
                wait_kind = WAIT_NONE;
                if (fmt == FMT_ADPCM) begin
                    loop_cap = 0;
                    fetch(WAIT_HEADER, src_addr, SIZE_WORD);
                end else if (fmt == FMT_PSG) begin
                    lfsr = 15'h7FFF;
                    duty_cnt = 0;
                    pos = -28'sd1;
                end
            end
            default: begin
                playing = 0;
                wait_kind = WAIT_NONE;
                pend_addr = 0;
                pend_size = 0;
            end
        endcase
        r.req = (wait_kind != WAIT_NONE);
        r.addr = r.req ? pend_addr : '0;
        r.size = r.req ? pend_size : '0;
        r.smp = cur_smp;
        r.on = playing;
    endtask

    task automatic report_mismatch(string what, longint want, longint got);
        $display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $realtime);
        failures++;
    endtask

    initial begin
        failures = 0;
        clear_state();
    end

    assign outstanding = expected_q.size();

    always @(posedge aclk) begin
        chan_result_t want, got;
        if (!aresetn) begin
            clear_state();
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[0], m_tdata[27:1], m_tdata[29:28], m_tdata[45:30], m_tdata[46]};
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected transaction", 0, m_tdata);
                end else begin
                    want = expected_q.pop_front();
                    if (got.req != want.req) report_mismatch("fetch_request", want.req, got.req);
                    if (got.addr != want.addr) report_mismatch("fetch_address", want.addr, got.addr);
                    if (got.size != want.size) report_mismatch("fetch_size", want.size, got.size);
                    if (got.smp != want.smp) report_mismatch("sample_out", want.smp, got.smp);
                    if (got.on != want.on) report_mismatch("channel_on", want.on, got.on);
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_FORMAT:  fmt = cfg_data[1:0];
                    REG_REPEAT:  rep = cfg_data[1:0];
                    REG_RELOAD:  reload = cfg_data[15:0];
                    REG_LOOP:    loop_words = cfg_data[15:0];
                    REG_LENGTH:  len_words = cfg_data[21:0];
                    REG_SOURCE:  src_addr = cfg_data[26:0];
                    REG_DUTY:    duty = cfg_data[2:0];
                    default:     chan = cfg_data[3:0];
                endcase
            end
            if (s_tvalid && s_tready) begin
                channel_item(s_tdata[1:0], s_tdata[13:2], s_tdata[45:14], want);
                expected_q.push_back(want);
            end
        end
    end

endmodule

/* tb/sound_channel_sample_engine_unit_test.sv */
// top of the sound channel sample engine testbench: clock, reset, register
// settings, stimulus and random stalls; depends on scse_pkg, the block and the checker
`timescale 1ns / 1ps

module sound_channel_sample_engine_unit_test;
    import scse_pkg::*;

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [47:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [47:0]          m_tdata;
    logic                 cfg_we = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    int                   failures;
    int                   outstanding;
    bit                   quiet = 0;
    int                   stall_left = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    sound_channel_sample_engine_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    sound_channel_sample_engine_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .failures(failures), .outstanding(outstanding)
    );

    // receiver stalls in bursts
    always @(posedge aclk) begin
        if (quiet) begin
            m_tready <= 1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 11);
            m_tready <= 0;
        end else begin
            m_tready <= 1;
        end
    end

    task automatic send(logic [1:0] func, logic [11:0] cyc, logic [31:0] d);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {2'b00, d, cyc, func};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
    endtask

    task automatic settings(logic [1:0] f, logic [1:0] r, logic [15:0] rl, logic [15:0] lp,
                            logic [21:0] ln, logic [26:0] sa, logic [2:0] dt, logic [3:0] ch);
        write_reg(REG_FORMAT, f);
        write_reg(REG_REPEAT, r);
        write_reg(REG_RELOAD, rl);
        write_reg(REG_LOOP, lp);
        write_reg(REG_LENGTH, ln);
        write_reg(REG_SOURCE, sa);
        write_reg(REG_DUTY, dt);
        write_reg(REG_CHANNEL, ch);
        cfg_we <= 0;
        @(posedge aclk);
    endtask

    task automatic random_items(int n);
        int k;
        repeat (n) begin
            k = $urandom_range(0, 99);
            if (k < 48) send(FUNC_TICK, $urandom_range(0, 4095), $urandom);
            else if (k < 90) send(FUNC_DATA, $urandom_range(0, 4095), $urandom);
            else if (k < 95) send(FUNC_KEY_ON, $urandom_range(0, 4095), $urandom);
            else send(FUNC_KEY_OFF, $urandom_range(0, 4095), $urandom);
        end
    endtask

    initial begin
        logic [1:0] f;
        logic [15:0] rl;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // pcm8 at the fastest rate, address wrap, sign extremes
        settings(FMT_PCM8, 2'd1, 16'hFFFF, 16'd0, 22'd1, 27'h7FFFFFF, 3'd0, 4'd0);
        send(FUNC_DATA, 12'd0, 32'h0);
        send(FUNC_TICK, 12'hFFF, 32'h0);
        send(FUNC_KEY_ON, 12'd0, 32'h0);
        send(FUNC_TICK, 12'd0, 32'h0);
        send(FUNC_TICK, 12'hFFF, 32'h0);
        send(FUNC_TICK, 12'hFFF, 32'h0);
        send(FUNC_DATA, 12'd0, 32'hFFFFFF80);
        send(FUNC_KEY_ON, 12'd0, 32'h0);
        send(FUNC_DATA, 12'hFFF, 32'h0000007F);
        send(FUNC_KEY_OFF, 12'd0, 32'h0);
        drain();

        // adpcm with clamped step index and the counter growing while waiting
        settings(FMT_ADPCM, 2'd1, 16'hFFFF, 16'd0, 22'd1, 27'h0, 3'd7, 4'd15);
        send(FUNC_KEY_ON, 12'd0, 32'h0);
        send(FUNC_TICK, 12'hFFF, 32'h0);
        send(FUNC_DATA, 12'd0, 32'h007F8000);
        send(FUNC_DATA, 12'd0, 32'hFFFFFFFF);
        send(FUNC_DATA, 12'd0, 32'h00000088);
        send(FUNC_TICK, 12'hFFF, 32'h0);
        send(FUNC_DATA, 12'd0, 32'h00000077);
        drain();

        // pcm16 extremes, then slowest period with format switched to noise mid fetch
        settings(FMT_PCM16, 2'd0, 16'hFFFF, 16'hFFFF, 22'h3FFFFF, 27'h7FFFFFF, 3'd7, 4'd15);
        send(FUNC_KEY_OFF, 12'd0, 32'h0);
        send(FUNC_KEY_ON, 12'd0, 32'h0);
        send(FUNC_TICK, 12'hFFF, 32'h0);
        send(FUNC_DATA, 12'd0, 32'h00008000);
        drain();
        settings(FMT_PSG, 2'd3, 16'd0, 16'hFFFF, 22'h3FFFFF, 27'h0, 3'd7, 4'd15);
        send(FUNC_TICK, 12'hFFF, 32'h0);
        send(FUNC_DATA, 12'd0, 32'h00007FFF);
        drain();

        for (int ph = 0; ph < 14; ph++) begin
            quiet = (ph >= 12);
            f = $urandom_range(0, 3);
            rl = (ph % 5 == 0) ? 16'hFFFF : 16'($urandom_range(63000, 65535));
            if (f == FMT_PSG && rl > 16'd65000) rl = 16'd65000;
            if ($urandom_range(0, 3) != 0) send(FUNC_KEY_OFF, 12'd0, $urandom);
            drain();
            settings(f, $urandom_range(0, 3), rl, $urandom_range(0, 3),
                     ($urandom_range(0, 9) == 0) ? 22'h3FFFFF : 22'($urandom_range(0, 6)),
                     $urandom_range(0, 27'h7FFFFFF), $urandom_range(0, 7),
                     $urandom_range(0, 15));
            send(FUNC_KEY_ON, 12'd0, $urandom);
            random_items(70);
        end
        drain();
        if (failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #50ms;
        $display("status: fail");
        $finish;
    end

endmodule
